[hw/rtl/binary_min_heap_queue_macros.svh]
// assertion macros for the min-heap queue checker
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define BMHQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/bmhq_pkg.sv]
// shared types and codes of the min-heap queue
package bmhq_pkg;

    // operation codes of a request beat
    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_PEEK    = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    // status codes of a response beat
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic               is_insert;
        logic               is_extract;
        logic signed [31:0] value;
    } t_cell_ctrl;

endpackage

[hw/rtl/bmhq_if.sv]
// request and response channel interfaces of the min-heap queue

// request channel: operation and value
interface bmhq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// response channel: returned minimum, status and occupancy
interface bmhq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [6:0]         occupancy;

    modport source (output valid, output result_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input result_value, input status, input occupancy,
                    output ready);
endinterface

[hw/rtl/bmhq_cell.sv]
// one cell of the sorted row: holds one entry, shifts with its neighbors
module bmhq_cell (
    input  logic                  i_clk,
    input  bmhq_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_occ,
    input  logic signed [31:0]    i_prev_val,
    input  logic                  i_prev_stay,
    input  logic signed [31:0]    i_next_val,
    output logic signed [31:0]    o_val,
    output logic                  o_stay
);

    logic signed [31:0] r_val;
    logic               w_stay;

    // entry stays put on insert when it is occupied and not above the new value
    assign w_stay = i_occ && !(i_ctrl.value < r_val);
    assign o_stay = w_stay;
    assign o_val  = r_val;

    // insert opens a slot and shifts larger entries right; extract shifts left
    always_ff @(posedge i_clk) begin
        if (i_ctrl.is_insert) begin
            if (!w_stay) begin
                r_val <= i_prev_stay ? i_ctrl.value : i_prev_val;
            end
        end else if (i_ctrl.is_extract) begin
            r_val <= i_next_val;
        end
    end

endmodule

[hw/rtl/binary_min_heap_queue.sv]
// top level of the min-heap priority queue built as a sorted row of cells
//
//   channel  dir  fields                              handshake
//   i_req    in   op, value                           valid / ready
//   o_rsp    out  result_value, status, occupancy     valid / ready
//
// in each operation every cell does one compare and one shift
// in parallel, and the response lands in an output register.
// a new request is taken while the held response is being taken.
// reset empties the queue at once; no clearing pass is needed.
// a stalled response holds the request side until it is taken.
module binary_min_heap_queue #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmhq_req_if.sink    i_req,
    bmhq_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_out_valid;
    logic signed [31:0]        r_res;
    logic signed [31:0]        n_res;
    bmhq_pkg::t_status         r_status;
    bmhq_pkg::t_status         n_status;
    logic [CW+6:0]             w_count_ext;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    bmhq_pkg::t_cell_ctrl      w_ctrl;

    logic signed [31:0]        w_val  [CAPACITY];
    logic                      w_stay [CAPACITY];

    // request side opens out of reset when no response is held or it leaves now
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // command to the row
    always_comb begin
        w_ctrl.is_insert  = w_accept && (i_req.op == bmhq_pkg::OP_INSERT) && !w_full;
        w_ctrl.is_extract = w_accept && (i_req.op == bmhq_pkg::OP_EXTRACT) && !w_empty;
        w_ctrl.value      = i_req.value;
    end

    // row of cells, smallest entry in cell zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(g);
        logic               w_prev_stay;
        logic signed [31:0] w_prev_val;
        logic signed [31:0] w_next_val;

        if (g == 0) begin : g_head
            assign w_prev_stay = 1'b1;
            assign w_prev_val  = i_req.value;
        end else begin : g_body
            assign w_prev_stay = w_stay[g-1];
            assign w_prev_val  = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_val = w_val[g];
        end else begin : g_mid
            assign w_next_val = w_val[g+1];
        end

        bmhq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_occ       (IDX < r_count),
            .i_prev_val  (w_prev_val),
            .i_prev_stay (w_prev_stay),
            .i_next_val  (w_next_val),
            .o_val       (w_val[g]),
            .o_stay      (w_stay[g])
        );
    end

    // response and next count
    always_comb begin
        n_res    = '0;
        n_status = bmhq_pkg::ST_OK;
        n_count  = r_count;
        unique case (i_req.op)
            bmhq_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = bmhq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            bmhq_pkg::OP_EXTRACT: begin
                if (w_empty) begin
                    n_status = bmhq_pkg::ST_EMPTY;
                end else begin
                    n_res   = w_val[0];
                    n_count = r_count - CW'(1);
                end
            end
            bmhq_pkg::OP_PEEK: begin
                if (w_empty) begin
                    n_status = bmhq_pkg::ST_EMPTY;
                end else begin
                    n_res = w_val[0];
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // count and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res    <= n_res;
            r_status <= n_status;
        end
    end

    assign w_count_ext        = {7'd0, r_count};
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_res;
    assign o_rsp.status       = r_status;
    assign o_rsp.occupancy    = w_count_ext[6:0];

endmodule

[hw/rtl/bmhq_checker.sv]
// port-level checks of the min-heap queue, bound to the top level
`include "binary_min_heap_queue_macros.svh"

module bmhq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic signed [31:0] i_rsp_result_value,
    input logic [1:0]         i_rsp_status,
    input logic [6:0]         i_rsp_occupancy
);

    // request side closes only while a response is held
    `BMHQ_ASSERT_NOW(a_ready_gap, !i_req_ready, i_rsp_valid, "request stalled with no response held")

    // empty status means nothing is held and nothing is returned
    `BMHQ_ASSERT_NOW(a_empty_rsp, i_rsp_valid && (i_rsp_status == bmhq_pkg::ST_EMPTY), (i_rsp_occupancy == 7'd0) && (i_rsp_result_value == 32'sd0), "empty response with data or entries")

    // a dropped insert returns no value
    `BMHQ_ASSERT_NOW(a_full_rsp, i_rsp_valid && (i_rsp_status == bmhq_pkg::ST_FULL), i_rsp_result_value == 32'sd0, "full response with nonzero value")

    // a stalled response beat holds its payload
    `BMHQ_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_result_value) && $stable(i_rsp_status) && $stable(i_rsp_occupancy), "stalled response changed")

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_result_value (o_rsp.result_value),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_occupancy    (o_rsp.occupancy)
);
